// ----- src/ert_pkg.sv -----
`default_nettype none

package ert_pkg;

   localparam int NUM_PLANES = 6;

   localparam logic [1:0] CMD_VIEWER = 2'd0;
   localparam logic [1:0] CMD_PLANE  = 2'd1;
   localparam logic [1:0] CMD_TEST   = 2'd2;

   localparam logic [2:0] STAGE_PASS    = 3'd0;
   localparam logic [2:0] STAGE_ROOM    = 3'd1;
   localparam logic [2:0] STAGE_RANGE   = 3'd2;
   localparam logic [2:0] STAGE_FRUSTUM = 3'd3;
   localparam logic [2:0] STAGE_VIS     = 3'd4;

   localparam logic [1:0] CSR_DEFAULT_RANGE = 2'd0;
   localparam logic [1:0] CSR_ROOM_EN       = 2'd1;
   localparam logic [1:0] CSR_FRUSTUM_EN    = 2'd2;
   localparam logic [1:0] CSR_VIS_EN        = 2'd3;

   localparam logic [23:0] DEFAULT_RANGE_RESET = 24'd25600;

   typedef struct packed {
      logic [23:0] default_range;
      logic        room_en;
      logic        frustum_en;
      logic        vis_en;
   } cfg_type;

   // One item as it travels down the chain of cells.
   typedef struct packed {
      logic               is_test;
      logic               is_plane;
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic signed [23:0] pz;
      logic [23:0]        reach;
      logic               persistent;
      logic               pvs;
      logic [2:0]         pidx;
      logic signed [23:0] poff;
      logic [2:0]         stage;
   } token_type;

endpackage

`default_nettype wire

// ----- src/ert_req_if.sv -----
`default_nettype none

interface ert_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic signed [23:0] pos_z;
   logic [23:0]        reach;
   logic [15:0]        room;
   logic               persistent;
   logic               pvs_visible;
   logic [2:0]         plane_index;
   logic signed [23:0] plane_offset;

   modport source (
      output valid, command, pos_x, pos_y, pos_z, reach, room, persistent,
             pvs_visible, plane_index, plane_offset,
      input  ready
   );
   modport sink (
      input  valid, command, pos_x, pos_y, pos_z, reach, room, persistent,
             pvs_visible, plane_index, plane_offset,
      output ready
   );
endinterface

`default_nettype wire

// ----- src/ert_rsp_if.sv -----
`default_nettype none

interface ert_rsp_if;
   logic       valid;
   logic       ready;
   logic       relevant;
   logic [2:0] reject_stage;

   modport source (output valid, relevant, reject_stage, input ready);
   modport sink (input valid, relevant, reject_stage, output ready);
endinterface

`default_nettype wire

// ----- src/ert_range_stage.sv -----
`default_nettype none

module ert_range_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ert_pkg::cfg_type   cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [1:0]         in_command,
   input  wire logic [15:0]        in_room,
   input  wire ert_pkg::token_type in_tok,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output ert_pkg::token_type      out_tok
);
   import ert_pkg::*;

   logic signed [23:0] viewer_x_ff, viewer_y_ff, viewer_z_ff;
   logic [23:0]        viewer_range_ff;
   logic [15:0]        viewer_room_ff;
   logic               viewer_load;

   logic               ready_a, ready_b, ready_c;

   // Stage A: differences to the viewer and the room compare.
   logic               a_valid_ff, a_valid_in;
   token_type          a_tok_ff;
   logic signed [24:0] a_dx_ff, a_dy_ff, a_dz_ff, a_dx_in, a_dy_in, a_dz_in;
   logic               a_room_fail_ff, a_room_fail_in;
   logic [23:0]        a_range_ff, a_range_in;

   // Stage B: squares.
   logic               b_valid_ff;
   token_type          b_tok_ff;
   logic [48:0]        b_sqx_ff, b_sqy_ff, b_sqz_ff, b_sqx_in, b_sqy_in, b_sqz_in;
   logic [47:0]        b_rsq_ff, b_rsq_in;
   logic               b_room_fail_ff;
   logic signed [49:0] prod_x, prod_y, prod_z;

   // Stage C: sum, compare and the stage code.
   logic               c_valid_ff;
   token_type          c_tok_ff, c_tok_in;
   logic [50:0]        dsq;

   assign ready_c  = !c_valid_ff || out_ready;
   assign ready_b  = !b_valid_ff || ready_c;
   assign ready_a  = !a_valid_ff || ready_b;
   assign in_ready = ready_a;

   assign viewer_load = in_valid && ready_a && (in_command == CMD_VIEWER);

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_x_ff     <= '0;
         viewer_y_ff     <= '0;
         viewer_z_ff     <= '0;
         viewer_range_ff <= '0;
         viewer_room_ff  <= '0;
      end else if (viewer_load) begin
         viewer_x_ff     <= in_tok.px;
         viewer_y_ff     <= in_tok.py;
         viewer_z_ff     <= in_tok.pz;
         viewer_range_ff <= in_tok.reach;
         viewer_room_ff  <= in_room;
      end
   end

   // Viewer loads end here; plane loads and tests go on down the chain.
   always_comb begin
      a_valid_in     = in_valid && (in_tok.is_test || in_tok.is_plane);
      a_dx_in        = $signed({in_tok.px[23], in_tok.px})
                       - $signed({viewer_x_ff[23], viewer_x_ff});
      a_dy_in        = $signed({in_tok.py[23], in_tok.py})
                       - $signed({viewer_y_ff[23], viewer_y_ff});
      a_dz_in        = $signed({in_tok.pz[23], in_tok.pz})
                       - $signed({viewer_z_ff[23], viewer_z_ff});
      a_room_fail_in = cfg.room_en && (in_room != viewer_room_ff);
      a_range_in     = (viewer_range_ff != '0) ? viewer_range_ff : cfg.default_range;
   end

   always_comb begin
      prod_x   = a_dx_ff * a_dx_ff;
      prod_y   = a_dy_ff * a_dy_ff;
      prod_z   = a_dz_ff * a_dz_ff;
      b_sqx_in = prod_x[48:0];
      b_sqy_in = prod_y[48:0];
      b_sqz_in = prod_z[48:0];
      b_rsq_in = a_range_ff * a_range_ff;
   end

   always_comb begin
      dsq      = {2'b00, b_sqx_ff} + {2'b00, b_sqy_ff} + {2'b00, b_sqz_ff};
      c_tok_in = b_tok_ff;
      if (b_tok_ff.persistent) begin
         c_tok_in.stage = STAGE_PASS;
      end else if (b_room_fail_ff) begin
         c_tok_in.stage = STAGE_ROOM;
      end else if (dsq > {3'b000, b_rsq_ff}) begin
         c_tok_in.stage = STAGE_RANGE;
      end else begin
         c_tok_in.stage = STAGE_PASS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (ready_a) a_valid_ff <= a_valid_in;
         if (ready_b) b_valid_ff <= a_valid_ff;
         if (ready_c) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         a_tok_ff       <= in_tok;
         a_dx_ff        <= a_dx_in;
         a_dy_ff        <= a_dy_in;
         a_dz_ff        <= a_dz_in;
         a_room_fail_ff <= a_room_fail_in;
         a_range_ff     <= a_range_in;
      end
      if (ready_b) begin
         b_tok_ff       <= a_tok_ff;
         b_sqx_ff       <= b_sqx_in;
         b_sqy_ff       <= b_sqy_in;
         b_sqz_ff       <= b_sqz_in;
         b_rsq_ff       <= b_rsq_in;
         b_room_fail_ff <= a_room_fail_ff;
      end
      if (ready_c) begin
         c_tok_ff <= c_tok_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_tok   = c_tok_ff;

endmodule

`default_nettype wire

// ----- src/ert_plane_cell.sv -----
`default_nettype none

module ert_plane_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ert_pkg::cfg_type   cfg,
   input  wire logic [2:0]         plane_id,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire ert_pkg::token_type in_tok,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output ert_pkg::token_type      out_tok
);
   import ert_pkg::*;

   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [23:0] offset_ff;
   logic               plane_load;

   logic               ready_m, ready_o;

   logic               m_valid_ff;
   token_type          m_tok_ff;
   logic signed [39:0] m_px_ff, m_py_ff, m_pz_ff, m_px_in, m_py_in, m_pz_in;
   logic signed [37:0] m_off_ff, m_off_in;

   logic               o_valid_ff;
   token_type          o_tok_ff, o_tok_in;
   logic signed [42:0] plane_dist, neg_r;

   assign ready_o  = !o_valid_ff || out_ready;
   assign ready_m  = !m_valid_ff || ready_o;
   assign in_ready = ready_m;

   // The plane is taken as its load item passes, so a test behind the load
   // sees the new plane and a test ahead of it the old one.
   assign plane_load = in_valid && ready_m && in_tok.is_plane && (in_tok.pidx == plane_id);

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff     <= '0;
         ny_ff     <= '0;
         nz_ff     <= '0;
         offset_ff <= '0;
      end else if (plane_load) begin
         nx_ff     <= in_tok.px[15:0];
         ny_ff     <= in_tok.py[15:0];
         nz_ff     <= in_tok.pz[15:0];
         offset_ff <= in_tok.poff;
      end
   end

   always_comb begin
      m_px_in  = nx_ff * in_tok.px;
      m_py_in  = ny_ff * in_tok.py;
      m_pz_in  = nz_ff * in_tok.pz;
      m_off_in = $signed({offset_ff, 14'b0});
   end

   always_comb begin
      plane_dist = 43'(m_px_ff) + 43'(m_py_ff) + 43'(m_pz_ff) + 43'(m_off_ff);
      neg_r      = -$signed({5'b0, m_tok_ff.reach, 14'b0});
      o_tok_in   = m_tok_ff;
      if (m_tok_ff.is_test && !m_tok_ff.persistent && cfg.frustum_en
          && (m_tok_ff.stage == STAGE_PASS) && (plane_dist < neg_r)) begin
         o_tok_in.stage = STAGE_FRUSTUM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (ready_m) m_valid_ff <= in_valid;
         if (ready_o) o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_m) begin
         m_tok_ff <= in_tok;
         m_px_ff  <= m_px_in;
         m_py_ff  <= m_py_in;
         m_pz_ff  <= m_pz_in;
         m_off_ff <= m_off_in;
      end
      if (ready_o) begin
         o_tok_ff <= o_tok_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_tok   = o_tok_ff;

endmodule

`default_nettype wire

// ----- src/entity_relevance_test.sv -----
`default_nettype none

// Relevance test for one entity against the loaded viewer: room, range,
// six-plane sphere culling and an external visibility bit, checked in that
// order. The block is a pipeline that takes one item per clock unless the
// output stalls: a range stage of three registers followed by a chain of plane
// cells of two registers each, one cell per frustum plane, and an output
// register. Loads take a slot in the pipeline like any other item and give no
// result. A viewer load takes effect for the next item; a plane load travels
// down the chain and is picked up by its cell, so every item sees the planes in
// the order in which they were loaded. Plane indices of NUM_PLANES and above
// match no cell and are dropped. When the result is not taken, the chain keeps
// filling until it is full.
module entity_relevance_test (
   input  wire logic  clock,
   input  wire logic  reset,
   ert_req_if.sink    req_if,
   ert_rsp_if.source  rsp_if,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_write_data
);
   import ert_pkg::*;

   cfg_type   cfg_ff;
   token_type req_tok;

   token_type           chain_tok   [NUM_PLANES+1];
   logic [NUM_PLANES:0] chain_valid;
   logic [NUM_PLANES:0] chain_ready;

   token_type  last_tok;
   logic       last_take;
   logic [2:0] final_stage;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_relevant_ff;
   logic [2:0] rsp_stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_range <= DEFAULT_RANGE_RESET;
         cfg_ff.room_en       <= 1'b0;
         cfg_ff.frustum_en    <= 1'b0;
         cfg_ff.vis_en        <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEFAULT_RANGE: cfg_ff.default_range <= csr_write_data;
            CSR_ROOM_EN:       cfg_ff.room_en       <= csr_write_data[0];
            CSR_FRUSTUM_EN:    cfg_ff.frustum_en    <= csr_write_data[0];
            CSR_VIS_EN:        cfg_ff.vis_en        <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req_tok.is_test    = (req_if.command == CMD_TEST);
      req_tok.is_plane   = (req_if.command == CMD_PLANE);
      req_tok.px         = req_if.pos_x;
      req_tok.py         = req_if.pos_y;
      req_tok.pz         = req_if.pos_z;
      req_tok.reach      = req_if.reach;
      req_tok.persistent = req_if.persistent;
      req_tok.pvs        = req_if.pvs_visible;
      req_tok.pidx       = req_if.plane_index;
      req_tok.poff       = req_if.plane_offset;
      req_tok.stage      = STAGE_PASS;
   end

   ert_range_stage u_range (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_command (req_if.command),
      .in_room    (req_if.room),
      .in_tok     (req_tok),
      .out_valid  (chain_valid[0]),
      .out_ready  (chain_ready[0]),
      .out_tok    (chain_tok[0])
   );

   for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
      ert_plane_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg_ff),
         .plane_id  (3'(i)),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_tok    (chain_tok[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_tok   (chain_tok[i+1])
      );
   end

   assign last_tok = chain_tok[NUM_PLANES];

   // Plane loads leave the chain here without a result.
   assign chain_ready[NUM_PLANES] = !last_tok.is_test || !rsp_valid_ff || rsp_if.ready;
   assign last_take = chain_valid[NUM_PLANES] && chain_ready[NUM_PLANES] && last_tok.is_test;

   always_comb begin
      final_stage = last_tok.stage;
      if (!last_tok.persistent && (last_tok.stage == STAGE_PASS) && cfg_ff.vis_en
          && !last_tok.pvs) begin
         final_stage = STAGE_VIS;
      end
      rsp_valid_in = last_take || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_take) begin
         rsp_relevant_ff <= (final_stage == STAGE_PASS);
         rsp_stage_ff    <= final_stage;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.relevant     = rsp_relevant_ff;
   assign rsp_if.reject_stage = rsp_stage_ff;

`ifndef ASSERT_OFF
   a_relevant_matches_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_relevant_ff == (rsp_stage_ff == STAGE_PASS)))
      else $error("relevant disagrees with the reject stage");

   a_stage_code_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_stage_ff <= STAGE_VIS))
      else $error("reject stage outside its codes");

   a_no_frustum_when_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !cfg_ff.frustum_en) |-> (rsp_stage_ff != STAGE_FRUSTUM))
      else $error("frustum rejection while the frustum check is off");

   a_plane_load_never_blocks: assert property (@(posedge clock) disable iff (reset)
      (chain_valid[NUM_PLANES] && !last_tok.is_test) |-> chain_ready[NUM_PLANES])
      else $error("plane load item held at the end of the chain");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import ert_pkg::*;

   // Number of pipeline registers that a test passes before its result appears.
   localparam int PIPE_DEPTH      = 3 + 2 * NUM_PLANES + 1;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STUCK_LIMIT     = 4000;
   localparam int PHASE_ITEMS     = 75;
   localparam int RANDOM_PHASES   = 8;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [23:0]        reach;
      logic [15:0]        room;
      logic               persistent;
      logic               pvs_visible;
      logic [2:0]         plane_index;
      logic signed [23:0] plane_offset;
   } entity_req_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_EVERY_K, READY_SPARSE} stall_mode_type;

   class relevance_scoreboard;
      logic [23:0]        fallback_range;
      bit                 room_gate;
      bit                 cull_gate;
      bit                 pvs_gate;
      logic signed [23:0] eye_x;
      logic signed [23:0] eye_y;
      logic signed [23:0] eye_z;
      logic [23:0]        eye_range;
      logic [15:0]        eye_room;
      logic signed [15:0] plane_n [NUM_PLANES][3];
      logic signed [23:0] plane_d [NUM_PLANES];
      logic [2:0]         expected_stages [$];
      int unsigned        mismatches;

      function new();
         fallback_range = DEFAULT_RANGE_RESET;
         room_gate = 1'b0;
         cull_gate = 1'b0;
         pvs_gate = 1'b0;
         eye_x = '0;
         eye_y = '0;
         eye_z = '0;
         eye_range = '0;
         eye_room = '0;
         foreach (plane_d[i]) begin
            plane_d[i] = '0;
            foreach (plane_n[i][j]) plane_n[i][j] = '0;
         end
         mismatches = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [23:0] value);
         case (idx)
            CSR_DEFAULT_RANGE: fallback_range = value;
            CSR_ROOM_EN:       room_gate = value[0];
            CSR_FRUSTUM_EN:    cull_gate = value[0];
            CSR_VIS_EN:        pvs_gate = value[0];
            default: ;
         endcase
      endfunction

      // The first check that fails decides the stage; persistent entities skip them all.
      function logic [2:0] classify(entity_req_type r);
         longint      dx, dy, dz, dsq, rsq, plane_dist, neg_r;
         logic [23:0] lim;
         if (r.persistent)
            return STAGE_PASS;
         lim = (eye_range != 0) ? eye_range : fallback_range;
         dx = longint'($signed(r.pos_x)) - longint'(eye_x);
         dy = longint'($signed(r.pos_y)) - longint'(eye_y);
         dz = longint'($signed(r.pos_z)) - longint'(eye_z);
         dsq = dx * dx + dy * dy + dz * dz;
         rsq = longint'(lim) * longint'(lim);
         if (room_gate && r.room != eye_room)
            return STAGE_ROOM;
         if (dsq > rsq)
            return STAGE_RANGE;
         if (cull_gate) begin
            neg_r = -(longint'(r.reach) * 16384);
            for (int i = 0; i < NUM_PLANES; i++) begin
               plane_dist = longint'(plane_n[i][0]) * longint'($signed(r.pos_x))
                          + longint'(plane_n[i][1]) * longint'($signed(r.pos_y))
                          + longint'(plane_n[i][2]) * longint'($signed(r.pos_z))
                          + longint'(plane_d[i]) * 16384;
               if (plane_dist < neg_r)
                  return STAGE_FRUSTUM;
            end
         end
         if (pvs_gate && !r.pvs_visible)
            return STAGE_VIS;
         return STAGE_PASS;
      endfunction

      function void note_request(entity_req_type r);
         case (r.command)
            CMD_VIEWER: begin
               eye_x = r.pos_x;
               eye_y = r.pos_y;
               eye_z = r.pos_z;
               eye_range = r.reach;
               eye_room = r.room;
            end
            CMD_PLANE: begin
               if (r.plane_index < NUM_PLANES) begin
                  plane_n[r.plane_index][0] = r.pos_x[15:0];
                  plane_n[r.plane_index][1] = r.pos_y[15:0];
                  plane_n[r.plane_index][2] = r.pos_z[15:0];
                  plane_d[r.plane_index] = r.plane_offset;
               end
            end
            CMD_TEST: expected_stages.push_back(classify(r));
            default: ;
         endcase
      endfunction

      function void check_response(logic relevant, logic [2:0] stage);
         logic [2:0] want;
         if (expected_stages.size() == 0) begin
            $error("result with no test waiting: relevant %0d, reject_stage %0d",
                   relevant, stage);
            mismatches++;
            return;
         end
         want = expected_stages.pop_front();
         if (relevant !== (want == STAGE_PASS)) begin
            $error("relevant: expected %0d, got %0d", want == STAGE_PASS, relevant);
            mismatches++;
         end
         if (stage !== want) begin
            $error("reject_stage: expected %0d, got %0d", want, stage);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_stages.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [23:0] csr_write_data;
   bit          hold_off_request = 1'b0;

   // Generator's view of the loaded viewer, so that tests land near it.
   logic signed [23:0] gen_vx = '0;
   logic signed [23:0] gen_vy = '0;
   logic signed [23:0] gen_vz = '0;
   logic [23:0]        gen_range = '0;
   logic [15:0]        gen_room = '0;
   logic [23:0]        gen_default = DEFAULT_RANGE_RESET;

   relevance_scoreboard sb;

   ert_req_if req_if ();
   ert_rsp_if rsp_if ();

   entity_relevance_test i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic offer(input entity_req_type r);
      req_if.valid        <= 1'b1;
      req_if.command      <= r.command;
      req_if.pos_x        <= r.pos_x;
      req_if.pos_y        <= r.pos_y;
      req_if.pos_z        <= r.pos_z;
      req_if.reach        <= r.reach;
      req_if.room         <= r.room;
      req_if.persistent   <= r.persistent;
      req_if.pvs_visible  <= r.pvs_visible;
      req_if.plane_index  <= r.plane_index;
      req_if.plane_offset <= r.plane_offset;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(r);
   endtask

   task automatic idle(input int unsigned cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Loads give no result, so after the last result the pipeline may still hold some.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [1:0] idx, input logic [23:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic program_config(input cfg_type c);
      put_reg(CSR_DEFAULT_RANGE, c.default_range);
      put_reg(CSR_ROOM_EN, {23'd0, c.room_en});
      put_reg(CSR_FRUSTUM_EN, {23'd0, c.frustum_en});
      put_reg(CSR_VIS_EN, {23'd0, c.vis_en});
      csr_write_enable <= 1'b0;
      gen_default = c.default_range;
   endtask

   function automatic entity_req_type mk(input logic [1:0] cmd, input int x, input int y,
                                         input int z, input int reach, input int room,
                                         input bit pers, input bit pvs, input int pidx,
                                         input int poff);
      entity_req_type r;
      r.command      = cmd;
      r.pos_x        = 24'(x);
      r.pos_y        = 24'(y);
      r.pos_z        = 24'(z);
      r.reach        = 24'(reach);
      r.room         = 16'(room);
      r.persistent   = pers;
      r.pvs_visible  = pvs;
      r.plane_index  = 3'(pidx);
      r.plane_offset = 24'(poff);
      return r;
   endfunction

   // pick below 7 gives a viewer load, below 14 a plane load, below 18 noise,
   // and anything else an entity test placed around the current viewer.
   function automatic entity_req_type make_item(input int unsigned pick);
      entity_req_type r;
      int             nrm [3];
      longint         acc;
      longint         span;
      logic [23:0]    eff;
      r.command      = CMD_TEST;
      r.pos_x        = 24'($urandom);
      r.pos_y        = 24'($urandom);
      r.pos_z        = 24'($urandom);
      r.reach        = 24'($urandom);
      r.room         = 16'($urandom);
      r.persistent   = 1'($urandom);
      r.pvs_visible  = 1'($urandom);
      r.plane_index  = 3'($urandom);
      r.plane_offset = 24'($urandom);
      if (pick < 7) begin
         r.command = CMD_VIEWER;
         r.pos_x = 24'(int'($urandom_range(0, 2097152)) - 1048576);
         r.pos_y = 24'(int'($urandom_range(0, 2097152)) - 1048576);
         r.pos_z = 24'(int'($urandom_range(0, 2097152)) - 1048576);
         case ($urandom_range(0, 3))
            0: r.reach = '0;
            1: r.reach = 24'($urandom_range(1, 65536));
            2: r.reach = 24'($urandom_range(65536, 2097152));
            default: ;
         endcase
         if ($urandom_range(0, 3) != 0)
            r.room = 16'($urandom_range(0, 3));
      end else if (pick < 14) begin
         r.command = CMD_PLANE;
         if (r.plane_index >= NUM_PLANES && $urandom_range(0, 1) == 1)
            r.plane_index = 3'($urandom_range(0, NUM_PLANES - 1));
         foreach (nrm[i])
            nrm[i] = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 65535)) - 32768;
         // Most planes pass close to the viewer so that both sides get entities.
         if ($urandom_range(0, 7) != 0) begin
            acc = longint'(nrm[0]) * longint'(gen_vx) + longint'(nrm[1]) * longint'(gen_vy)
                + longint'(nrm[2]) * longint'(gen_vz);
            acc = -(acc >>> 14) + longint'($urandom_range(0, 8192)) - 4096;
            if (acc > 8388607)
               acc = 8388607;
            if (acc < -8388608)
               acc = -8388608;
            r.plane_offset = 24'(acc);
         end
         r.pos_x = {r.pos_x[23:16], 16'(nrm[0])};
         r.pos_y = {r.pos_y[23:16], 16'(nrm[1])};
         r.pos_z = {r.pos_z[23:16], 16'(nrm[2])};
      end else if (pick < 18) begin
         r.command = ($urandom_range(0, 1) == 1) ? CMD_UNUSED : 2'($urandom);
      end else begin
         eff = (gen_range != 0) ? gen_range : gen_default;
         case ($urandom_range(0, 3))
            0: span = eff / 2;
            1: span = eff;
            2: span = 2 * longint'(eff);
            default: span = 256;
         endcase
         r.pos_x = 24'(longint'(gen_vx) + longint'($urandom_range(0, 2 * span)) - span);
         r.pos_y = 24'(longint'(gen_vy) + longint'($urandom_range(0, 2 * span)) - span);
         r.pos_z = 24'(longint'(gen_vz) + longint'($urandom_range(0, 2 * span)) - span);
         if ($urandom_range(0, 3) != 0)
            r.reach = 24'($urandom_range(0, 4096));
         r.persistent = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 6) != 0)
            r.room = gen_room;
      end
      if (r.command == CMD_VIEWER) begin
         gen_vx = r.pos_x;
         gen_vy = r.pos_y;
         gen_vz = r.pos_z;
         gen_range = r.reach;
         gen_room = r.room;
      end
      return r;
   endfunction

   task automatic run_phase(input cfg_type c, input bit hold);
      entity_req_type r;
      int             counted;
      int unsigned    burst;
      settle();
      program_config(c);
      if (hold)
         hold_off_request = 1'b1;
      offer(make_item(0));
      counted = 1;
      while (counted < PHASE_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && counted < PHASE_ITEMS; k++) begin
            r = make_item($urandom_range(0, 99));
            offer(r);
            if (r.command != CMD_UNUSED &&
                !(r.command == CMD_PLANE && r.plane_index >= NUM_PLANES))
               counted++;
         end
         if ($urandom_range(0, 2) != 0)
            idle($urandom_range(1, 8));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.relevant, rsp_if.reject_stage);
   end

   initial begin : receiver
      stall_mode_type mode;
      int unsigned    left, k, tick;
      rsp_if.ready <= 1'b0;
      mode = READY_ALWAYS;
      left = 0;
      k = 2;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end
         if (left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            left = $urandom_range(20, 120);
            k = $urandom_range(2, 5);
         end
         left--;
         tick++;
         case (mode)
            READY_ALWAYS:  rsp_if.ready <= 1'b1;
            READY_COIN:    rsp_if.ready <= 1'($urandom);
            READY_EVERY_K: rsp_if.ready <= (tick % k == 0);
            default:       rsp_if.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("entity_relevance_test regression: fail");
      $finish;
   end

   initial begin : stimulus
      cfg_type c;
      sb = new();
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_DEFAULT_RANGE;
      csr_write_data      <= '0;
      req_if.valid        <= 1'b0;
      req_if.command      <= CMD_TEST;
      req_if.pos_x        <= '0;
      req_if.pos_y        <= '0;
      req_if.pos_z        <= '0;
      req_if.reach        <= '0;
      req_if.room         <= '0;
      req_if.persistent   <= 1'b0;
      req_if.pvs_visible  <= 1'b0;
      req_if.plane_index  <= '0;
      req_if.plane_offset <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: only the range check is active, with the default range.
      offer(mk(CMD_TEST, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      offer(mk(CMD_TEST, 25600, 0, 0, 0, 0, 0, 1, 0, 0));
      offer(mk(CMD_TEST, 0, 0, -25601, 0, 0, 0, 1, 0, 0));
      offer(mk(CMD_TEST, 8388607, -8388608, 8388607, 16777215, 65535, 1, 0, 7, -8388608));
      offer(mk(CMD_TEST, -8388608, 8388607, -8388608, 16777215, 65535, 0, 1, 0, 8388607));
      offer(mk(CMD_UNUSED, -1, -1, -1, 16777215, 65535, 1, 1, 7, -1));
      offer(mk(CMD_VIEWER, -8388608, -8388608, -8388608, 16777215, 65535, 0, 0, 0, 0));
      offer(mk(CMD_TEST, 8388607, 8388607, 8388607, 0, 65535, 0, 1, 0, 0));
      offer(mk(CMD_TEST, -8388608, -8388608, -8388608, 16777215, 0, 0, 0, 0, 0));
      offer(mk(CMD_PLANE, 16384, 16384, 16384, 0, 0, 0, 0, 7, 8388607));
      offer(mk(CMD_PLANE, -16384, 0, 0, 0, 0, 0, 0, 6, -8388608));

      settle();
      c.default_range = 24'd16777215;
      c.room_en = 1'b1;
      c.frustum_en = 1'b1;
      c.vis_en = 1'b1;
      program_config(c);
      offer(mk(CMD_VIEWER, 0, 0, 0, 0, 5, 0, 0, 0, 0));
      // Normal of +1.0 along x with junk in the bits above the normal.
      offer(mk(CMD_PLANE, 'hFF4000, 0, 0, 0, 0, 0, 0, 0, 0));
      offer(mk(CMD_TEST, -256, 0, 0, 256, 5, 0, 1, 0, 0));
      offer(mk(CMD_TEST, -257, 0, 0, 256, 5, 0, 1, 0, 0));
      offer(mk(CMD_TEST, 0, 0, 0, 0, 6, 0, 1, 0, 0));
      offer(mk(CMD_TEST, 0, 0, 0, 0, 5, 0, 0, 0, 0));
      offer(mk(CMD_TEST, -8388608, -8388608, -8388608, 0, 6, 1, 0, 0, 0));
      offer(mk(CMD_PLANE, 0, 0, 'h008000, 0, 0, 0, 0, 5, 8388607));
      offer(mk(CMD_TEST, 0, 0, 8388607, 0, 5, 0, 1, 0, 0));

      // A default range of zero lets only the viewer's own position through.
      settle();
      c.default_range = '0;
      c.room_en = 1'b0;
      c.frustum_en = 1'b0;
      c.vis_en = 1'b0;
      program_config(c);
      offer(mk(CMD_TEST, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      offer(mk(CMD_TEST, 0, 1, 0, 0, 0, 0, 1, 0, 0));
      offer(mk(CMD_VIEWER, 100, 0, 0, 1, 0, 0, 0, 0, 0));
      offer(mk(CMD_TEST, 100, 1, 0, 0, 0, 0, 1, 0, 0));
      offer(mk(CMD_TEST, 101, 1, 0, 0, 0, 0, 1, 0, 0));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               c.default_range = DEFAULT_RANGE_RESET;
               {c.room_en, c.frustum_en, c.vis_en} = 3'b000;
            end
            1: begin
               c.default_range = 24'd16777215;
               {c.room_en, c.frustum_en, c.vis_en} = 3'b111;
            end
            2: begin
               c.default_range = 24'd1;
               {c.room_en, c.frustum_en, c.vis_en} = 3'b111;
            end
            default: begin
               c.default_range = ($urandom_range(0, 1) == 1) ?
                                 24'($urandom_range(1, 1048576)) :
                                 24'($urandom_range(1, 16777215));
               {c.room_en, c.frustum_en, c.vis_en} = 3'($urandom);
            end
         endcase
         run_phase(c, p == 3);
      end

      settle();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("entity_relevance_test regression: pass");
      else
         $display("entity_relevance_test regression: fail");
      $finish;
   end

endmodule
